@@ hdl/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the captive portal redirect block
// Opcodes, actions, table cell status and the HTTP method compare.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_NOTIFY = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [2:0] ACT_PASS        = 3'd0;
    localparam logic [2:0] ACT_REDIRECT    = 3'd1;
    localparam logic [2:0] ACT_DROP_FULL   = 3'd2;
    localparam logic [2:0] ACT_NOTIFY_OK   = 3'd3;
    localparam logic [2:0] ACT_NOTIFY_FULL = 3'd4;
    localparam logic [2:0] ACT_FLUSHED     = 3'd5;

    localparam logic [15:0] WEB_DST_PORT = 16'd80;

    localparam int MAC_W = 48;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic        flush;     // clear valid
        logic        upd;       // update matching entry
        logic        ins;       // insert at first free
        logic [1:0]  dtype;     // type to write
        logic        mark;      // mark value to write
        logic        set_type;  // write type on update
    } t_cmd;

    // Result of the lookup, gathered along the chain.
    typedef struct packed {
        logic       hit;
        logic [1:0] dtype;
        logic       marked;
    } t_look;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } t_state;

    function automatic logic is_http(input logic [55:0] h);
        logic r;
        r = 1'b0;
        if (h[55:32] == "GET") r = 1'b1;
        if (h[55:24] == "POST") r = 1'b1;
        if (h[55:32] == "PUT") r = 1'b1;
        if (h[55:0] == "OPTIONS") r = 1'b1;
        if (h[55:24] == "HEAD") r = 1'b1;
        if (h[55:8] == "DELETE") r = 1'b1;
        if (h[55:16] == "TRACE") r = 1'b1;
        return r;
    endfunction

endpackage

@@ hdl/cpr_cell.sv @@
// ----------------------------------------------------------------------------
// cpr_cell: one device table entry
// Matches its MAC, passes the lookup and the free-slot token to the next cell.
// ----------------------------------------------------------------------------
module cpr_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [47:0]          i_mac,
    input  logic                 i_we,
    input  cpr_pkg::t_cmd        i_cmd,
    input  cpr_pkg::t_look       i_look,
    output cpr_pkg::t_look       o_look,
    input  logic                 i_free_in,   // a lower slot is free
    output logic                 o_free_out
);
    import cpr_pkg::*;

    logic        r_valid;
    logic [47:0] r_mac;
    logic [1:0]  r_type;
    logic        r_mark;
    logic        w_hit;
    logic        w_ins;

    assign w_hit = r_valid && (r_mac == i_mac);
    assign w_ins = !r_valid && !i_free_in;
    assign o_free_out = i_free_in || !r_valid;

    always_comb begin
        o_look = i_look;
        if (w_hit) begin
            o_look.hit    = 1'b1;
            o_look.dtype  = r_type;
            o_look.marked = r_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_we) begin
            if (i_cmd.flush) begin
                r_valid <= 1'b0;
            end else if (i_cmd.upd && w_hit) begin
                if (i_cmd.set_type) r_type <= i_cmd.dtype;
                r_mark <= i_cmd.mark;
            end else if (i_cmd.ins && w_ins) begin
                r_valid <= 1'b1;
                r_mac   <= i_mac;
                r_type  <= i_cmd.dtype;
                r_mark  <= i_cmd.mark;
            end
        end
    end

endmodule

@@ hdl/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl: request sequencer
// Classifies the request, decides the table command and builds the result.
// ----------------------------------------------------------------------------
module cpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_opcode,
    input  logic [4:0]     i_packet_flags,
    input  logic [15:0]    i_dst_port,
    input  logic [55:0]    i_payload_head,
    input  logic [15:0]    i_payload_len,
    input  logic [3:0]     i_tcp_flags,
    input  logic [31:0]    i_tcp_seq,
    input  logic [31:0]    i_tcp_ack_seq,
    input  logic [1:0]     i_dev_type,
    input  logic           i_force_enable,
    input  logic [2:0]     i_mask,
    input  cpr_pkg::t_look i_look,
    input  logic           i_full,
    output logic           o_cap,
    output logic           o_we,
    output cpr_pkg::t_cmd  o_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_action,
    output logic [1:0]     o_portal_type,
    output logic [31:0]    o_reply_seq,
    output logic [31:0]    o_reply_ack
);
    import cpr_pkg::*;

    t_state r_state, n_state;
    logic [1:0]  r_op;
    logic        r_qual, r_supp;
    logic [31:0] r_rseq, r_rack;
    logic [2:0]  r_act;
    logic [1:0]  r_pt;
    logic        w_en;
    logic        w_go;
    logic [2:0]  w_act;
    logic [1:0]  w_pt;

    assign o_cap = (r_state == S_IDLE) && i_valid;
    assign w_en  = (i_look.dtype != 2'd3) && i_mask[i_look.dtype];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_LOOK;
            S_LOOK: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
        o_we    = (r_state == S_LOOK);
        o_cmd   = '0;
        w_go    = 1'b0;
        w_act   = ACT_PASS;
        w_pt    = 2'd0;
        unique case (r_op)
            OP_NOTIFY: begin
                o_cmd.upd = 1'b1;
                o_cmd.set_type = 1'b1;
                o_cmd.dtype = i_dev_type;
                o_cmd.ins = !i_look.hit;
                w_act = (i_look.hit || !i_full) ? ACT_NOTIFY_OK : ACT_NOTIFY_FULL;
            end
            OP_FLUSH: begin
                o_cmd.flush = 1'b1;
                w_act = ACT_FLUSHED;
            end
            OP_PACKET: begin
                if (r_qual) begin
                    o_cmd.mark = 1'b1;
                    if (i_look.hit) begin
                        o_cmd.upd = w_en && !i_look.marked;
                        w_go = o_cmd.upd;
                        w_pt = i_look.dtype;
                    end else if (i_mask[0]) begin
                        o_cmd.ins = 1'b1;
                        w_go = !i_full;
                        if (i_full) w_act = ACT_DROP_FULL;
                    end
                end
                if (w_go && !r_supp) w_act = ACT_REDIRECT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (o_cap) begin
            r_op   <= i_opcode;
            r_qual <= i_force_enable && (i_packet_flags[3:0] == 4'b0100)
                   && (i_dst_port == WEB_DST_PORT) && (i_payload_len != 16'd0)
                   && is_http(i_payload_head);
            r_supp <= i_packet_flags[4] || i_tcp_flags[3];
            r_rseq <= i_tcp_flags[2] ? i_tcp_ack_seq : 32'd0;
            r_rack <= i_tcp_seq + {31'd0, i_tcp_flags[0]} + {31'd0, i_tcp_flags[1]}
                    + {16'd0, i_payload_len};
        end
        if (r_state == S_LOOK) begin
            r_act <= w_act;
            r_pt  <= w_pt;
        end
    end

    assign o_action      = r_act;
    assign o_portal_type = (r_act == ACT_REDIRECT) ? r_pt : 2'd0;
    assign o_reply_seq   = (r_act == ACT_REDIRECT) ? r_rseq : 32'd0;
    assign o_reply_ack   = (r_act == ACT_REDIRECT) ? r_rack : 32'd0;

endmodule

@@ hdl/captive_portal_first_request_redirect.sv @@
// ----------------------------------------------------------------------------
// captive_portal_first_request_redirect: first HTTP request redirect engine
// Device table as a chain of cells plus a request sequencer.
// ----------------------------------------------------------------------------
// Each request passes capture, one pass of the MAC match and lowest-free-slot
// token along the cell chain (where the table is updated at the end of that
// pass), then the result register and output wait. The chain length
// TABLE_ENTRIES sets the lookup path depth. Reset empties the table at once;
// a flush request does the same in its update cycle. Configuration index 0
// is force_enable, index 1 is device_enable_mask.
module captive_portal_first_request_redirect #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [47:0] i_mac,
    input  logic [1:0]  i_dev_type,
    input  logic [4:0]  i_packet_flags,
    input  logic [15:0] i_dst_port,
    input  logic [55:0] i_payload_head,
    input  logic [15:0] i_payload_len,
    input  logic [3:0]  i_tcp_flags,
    input  logic [31:0] i_tcp_seq,
    input  logic [31:0] i_tcp_ack_seq,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [1:0]  o_portal_type,
    output logic [31:0] o_reply_seq,
    output logic [31:0] o_reply_ack
);
    import cpr_pkg::*;

    logic        r_force;
    logic [2:0]  r_mask;
    logic [47:0] r_mac;
    logic [1:0]  r_dtype;
    logic        w_cap, w_we;
    t_cmd        w_cmd;
    t_look       w_look [TABLE_ENTRIES+1];
    logic        w_free [TABLE_ENTRIES+1];

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b0;
            r_mask  <= 3'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index) r_mask  <= i_cfg_data;
            else             r_force <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_mac   <= i_mac;
            r_dtype <= i_dev_type;
        end
    end

    assign w_look[0] = '0;
    assign w_free[0] = 1'b0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        cpr_cell u_cell (
            .i_clk, .i_rst_n,
            .i_mac     (r_mac),
            .i_we      (w_we),
            .i_cmd     (w_cmd),
            .i_look    (w_look[g]),
            .o_look    (w_look[g+1]),
            .i_free_in (w_free[g]),
            .o_free_out(w_free[g+1])
        );
    end

    cpr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_opcode, .i_packet_flags, .i_dst_port, .i_payload_head,
        .i_payload_len, .i_tcp_flags, .i_tcp_seq, .i_tcp_ack_seq,
        .i_dev_type     (r_dtype),
        .i_force_enable (r_force),
        .i_mask         (r_mask),
        .i_look         (w_look[TABLE_ENTRIES]),
        .i_full         (!w_free[TABLE_ENTRIES]),
        .o_cap          (w_cap),
        .o_we           (w_we),
        .o_cmd          (w_cmd),
        .o_valid, .i_ready, .o_action, .o_portal_type, .o_reply_seq, .o_reply_ack
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for captive_portal_first_request_redirect
// Directed table then random traffic against an in-bench device table model,
// with random sender and receiver idling and several enable settings.
// ----------------------------------------------------------------------------
module tb;
    import cpr_pkg::*;

    localparam int ENTRIES  = 64;
    localparam int MAC_POOL = 96;

    typedef struct {
        logic [1:0]  opcode;
        logic [47:0] mac;
        logic [1:0]  dev_type;
        logic [4:0]  pflags;
        logic [15:0] dport;
        logic [55:0] head;
        logic [15:0] plen;
        logic [3:0]  tflags;
        logic [31:0] seq;
        logic [31:0] ackseq;
    } t_req;

    typedef struct {
        logic [2:0]  action;
        logic [1:0]  ptype;
        logic [31:0] rseq;
        logic [31:0] rack;
    } t_verdict;

    // one directed row: optional config write first, optional typed verdict
    typedef struct {
        bit       cfg_first;
        bit       fe;
        bit [2:0] mask;
        t_req     r;
        bit       typed;
        t_verdict v;
    } t_row;

    // packet flag and tcp flag bit positions
    localparam int PF_REPLY = 0, PF_LOCAL = 1, PF_TCP = 2, PF_WAN = 3, PF_FRAG = 4;
    localparam int TF_SYN = 0, TF_FIN = 1, TF_ACK = 2, TF_RST = 3;
    localparam bit CFG_FORCE = 1'b0, CFG_MASK = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [47:0] i_mac = '0;
    logic [1:0]  i_dev_type = '0;
    logic [4:0]  i_packet_flags = '0;
    logic [15:0] i_dst_port = '0;
    logic [55:0] i_payload_head = '0;
    logic [15:0] i_payload_len = '0;
    logic [3:0]  i_tcp_flags = '0;
    logic [31:0] i_tcp_seq = '0;
    logic [31:0] i_tcp_ack_seq = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_action;
    logic [1:0]  o_portal_type;
    logic [31:0] o_reply_seq;
    logic [31:0] o_reply_ack;

    captive_portal_first_request_redirect #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // timeout guard
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Device table model
    // ------------------------------------------------------------------
    bit          m_force;
    bit [2:0]    m_mask;
    bit          m_valid [ENTRIES];
    logic [47:0] m_mac   [ENTRIES];
    logic [1:0]  m_type  [ENTRIES];
    bit          m_mark  [ENTRIES];

    t_verdict    verdict_q[$];
    int          err_count = 0;
    int          tx_idle_pct = 23;
    int          rx_idle_pct = 82;
    logic [47:0] mac_pool[MAC_POOL];

    // methods left aligned in 56 bits, with byte length
    function automatic logic [55:0] method_word(int k);
        case (k)
            0: return {"GET", 32'h0};
            1: return {"POST", 24'h0};
            2: return {"PUT", 32'h0};
            3: return "OPTIONS";
            4: return {"HEAD", 24'h0};
            5: return {"DELETE", 8'h0};
            default: return {"TRACE", 16'h0};
        endcase
    endfunction

    function automatic int method_len(int k);
        case (k)
            0, 2: return 3;
            1, 4: return 4;
            3: return 7;
            5: return 6;
            default: return 5;
        endcase
    endfunction

    // method prefix with the rest of the head filled from tail
    function automatic logic [55:0] http_head(int k, logic [55:0] tail);
        logic [55:0] keep;
        keep = ~56'h0 << (56 - 8 * method_len(k));
        return (method_word(k) & keep) | (tail & ~keep);
    endfunction

    function automatic bit starts_http(logic [55:0] h);
        int sh;
        for (int k = 0; k < 7; k++) begin
            sh = 56 - 8 * method_len(k);
            if ((h >> sh) == (method_word(k) >> sh)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit type_on(logic [1:0] t);
        return (t != 2'd3) && m_mask[t];
    endfunction

    function automatic int lookup_mac(logic [47:0] mac);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_mac[i] == mac) return i;
        return -1;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < ENTRIES; i++)
            if (!m_valid[i]) return i;
        return -1;
    endfunction

    function automatic void clear_devices();
        for (int i = 0; i < ENTRIES; i++) begin
            m_valid[i] = 1'b0;
            m_mark[i]  = 1'b0;
        end
    endfunction

    // apply one request to the table model and return its verdict
    function automatic t_verdict predict_verdict(t_req r);
        t_verdict v;
        int       slot;
        bit       hit_ok;
        bit       qual;
        logic [1:0] pt;
        v = '{ACT_PASS, 2'd0, 32'd0, 32'd0};
        hit_ok = 1'b0;
        pt = 2'd0;
        if (r.opcode == OP_NOTIFY) begin
            slot = lookup_mac(r.mac);
            if (slot < 0) begin
                slot = lowest_free();
                if (slot >= 0) begin
                    m_valid[slot] = 1'b1;
                    m_mac[slot] = r.mac;
                end
            end
            if (slot >= 0) begin
                m_type[slot] = r.dev_type;
                m_mark[slot] = 1'b0;
                v.action = ACT_NOTIFY_OK;
            end else begin
                v.action = ACT_NOTIFY_FULL;
            end
        end else if (r.opcode == OP_FLUSH) begin
            clear_devices();
            v.action = ACT_FLUSHED;
        end else if (r.opcode == OP_PACKET) begin
            qual = m_force && !r.pflags[PF_REPLY] && !r.pflags[PF_LOCAL]
                && r.pflags[PF_TCP] && r.dport == WEB_DST_PORT && !r.pflags[PF_WAN]
                && r.plen != 0 && starts_http(r.head);
            if (qual) begin
                slot = lookup_mac(r.mac);
                if (slot >= 0) begin
                    if (type_on(m_type[slot]) && !m_mark[slot]) begin
                        m_mark[slot] = 1'b1;
                        pt = m_type[slot];
                        hit_ok = 1'b1;
                    end
                end else if (type_on(2'd0)) begin
                    slot = lowest_free();
                    if (slot >= 0) begin
                        m_valid[slot] = 1'b1;
                        m_mac[slot] = r.mac;
                        m_type[slot] = 2'd0;
                        m_mark[slot] = 1'b1;
                        hit_ok = 1'b1;
                    end else begin
                        v.action = ACT_DROP_FULL;
                    end
                end
                // device is marked even if RST or fragment hides the redirect
                if (hit_ok && !r.pflags[PF_FRAG] && !r.tflags[TF_RST]) begin
                    v.action = ACT_REDIRECT;
                    v.ptype = pt;
                    v.rseq = r.tflags[TF_ACK] ? r.ackseq : 32'd0;
                    v.rack = r.seq + r.tflags[TF_SYN] + r.tflags[TF_FIN] + r.plen;
                end
            end
        end
        return v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready and result check against the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict w;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report("unexpected result action", o_action, 0);
            end else begin
                w = verdict_q.pop_front();
                if (o_action !== w.action) report("action", o_action, w.action);
                if (o_portal_type !== w.ptype) report("portal_type", o_portal_type, w.ptype);
                if (o_reply_seq !== w.rseq) report("reply_seq", o_reply_seq, w.rseq);
                if (o_reply_ack !== w.rack) report("reply_ack", o_reply_ack, w.rack);
            end
        end
        i_ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_request(t_req r, bit typed, t_verdict tv);
        t_verdict p;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= r.opcode;
        i_mac          <= r.mac;
        i_dev_type     <= r.dev_type;
        i_packet_flags <= r.pflags;
        i_dst_port     <= r.dport;
        i_payload_head <= r.head;
        i_payload_len  <= r.plen;
        i_tcp_flags    <= r.tflags;
        i_tcp_seq      <= r.seq;
        i_tcp_ack_seq  <= r.ackseq;
        do @(posedge i_clk); while (!o_ready);
        // model advances on acceptance; typed rows keep their own verdict
        p = predict_verdict(r);
        verdict_q.push_back(typed ? tv : p);
    endtask

    // write a register once all results are in and the pipe has drained
    task automatic write_reg(bit idx, logic [2:0] val);
        i_valid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FORCE) m_force = val[0];
        else m_mask = val;
    endtask

    function automatic t_req mk(logic [1:0] op, logic [47:0] mac, logic [1:0] dt,
                                logic [4:0] pf, logic [15:0] dp, logic [55:0] hd,
                                logic [15:0] pl, logic [3:0] tf, logic [31:0] sq,
                                logic [31:0] ak);
        t_req r;
        r = '{op, mac, dt, pf, dp, hd, pl, tf, sq, ak};
        return r;
    endfunction

    // well-formed HTTP request from the MAC pool, sometimes broken on purpose
    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        r = mk(OP_PACKET, mac_pool[$urandom_range(MAC_POOL - 1)], 2'($urandom_range(3)),
               5'b00100, WEB_DST_PORT, http_head($urandom_range(6), 56'({$urandom, $urandom})),
               16'($urandom_range(1, 65535)), 4'($urandom_range(7)), $urandom, $urandom);
        if ($urandom_range(9) == 0) r.tflags[TF_RST] = 1'b1;
        if ($urandom_range(9) == 0) r.pflags[PF_FRAG] = 1'b1;
        if ($urandom_range(3) == 0) r.plen = 16'($urandom_range(1, 1500));
        if (pick < 10) begin
            r.opcode = OP_NOTIFY;
        end else if (pick < 12) begin
            r.opcode = OP_FLUSH;
        end else if (pick < 14) begin
            r.opcode = 2'd3;
        end else if (pick < 20) begin
            // raw noise in every field
            r = mk(2'($urandom_range(3)), 48'({$urandom, $urandom}), 2'($urandom),
                   5'($urandom), 16'($urandom), 56'({$urandom, $urandom}),
                   16'($urandom), 4'($urandom), $urandom, $urandom);
        end else if (pick < 34) begin
            case ($urandom_range(6))
                0: r.pflags[PF_REPLY] = 1'b1;
                1: r.pflags[PF_LOCAL] = 1'b1;
                2: r.pflags[PF_TCP] = 1'b0;
                3: r.pflags[PF_WAN] = 1'b1;
                4: r.dport = 16'($urandom);
                5: r.plen = 16'd0;
                default: r.head = 56'({$urandom, $urandom});
            endcase
        end
        return r;
    endfunction

    t_row        rows[$];
    t_verdict    none;
    t_verdict    vpass, vok, vflush;
    logic [55:0] tail;

    initial begin
        t_row     rw;
        t_req     base;
        bit [3:0] phase_cfg [7];
        none   = '{ACT_PASS, 2'd0, 32'd0, 32'd0};
        vpass  = none;
        vok    = '{ACT_NOTIFY_OK, 2'd0, 32'd0, 32'd0};
        vflush = '{ACT_FLUSHED, 2'd0, 32'd0, 32'd0};
        m_force = 1'b0;
        m_mask = 3'd0;
        clear_devices();
        for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = 48'({$urandom, $urandom});
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        tail = 56'h20_2F_20_48_54_54_50;

        // qualifying HTTP packet template
        base = mk(OP_PACKET, 48'h0, 2'd0, 5'b00100, WEB_DST_PORT, http_head(0, tail),
                  16'd40, 4'b0100, 32'h1000, 32'h2000);

        // directed table
        rw = '{0, 0, 0, base, 1, vpass};                 // force off after reset
        rows.push_back(rw);
        rw.r = mk(OP_NOTIFY, 48'h0, 2'd0, 0, 0, 0, 0, 0, 0, 0);
        rw.v = vok;
        rows.push_back(rw);
        rw = '{1, 1, 3'd7, base, 0, none};                // all portals on
        rw.r.mac = 48'hFFFF_FFFF_FFFF;
        rw.r.tflags = 4'b0111;
        rw.r.ackseq = 32'hFFFF_FFFF;
        rows.push_back(rw);
        rw = '{0, 0, 0, rw.r, 1, vpass};                  // second request passes
        rows.push_back(rw);
        for (int k = 1; k < 7; k++) begin                 // the other methods
            rw = '{0, 0, 0, base, 0, none};
            rw.r.mac = 48'h0200_0000_0010 + k;
            rw.r.head = http_head(k, ~56'h0);
            rw.r.tflags = 4'(k);
            if (k == 1) begin
                rw.r.plen = 16'hFFFF;
                rw.r.seq = 32'hFFFF_FFFF;
            end
            rows.push_back(rw);
        end
        rw = '{0, 0, 0, base, 1, vpass};                  // RST hides the redirect
        rw.r.mac = 48'h0200_0000_0020;
        rw.r.tflags = 4'b1100;
        rows.push_back(rw);
        rows.push_back(rw);                               // now marked
        rw.r.mac = 48'h0200_0000_0021;                    // fragment
        rw.r.tflags = 4'b0100;
        rw.r.pflags = 5'b10100;
        rows.push_back(rw);
        rw = '{0, 0, 0, mk(OP_NOTIFY, 48'h0200_0000_0020, 2'd1, 0, 0, 0, 0, 0, 0, 0),
               1, vok};                                   // re-notify clears mark
        rows.push_back(rw);
        rw = '{0, 0, 0, base, 0, none};
        rw.r.mac = 48'h0200_0000_0020;
        rows.push_back(rw);
        rw = '{0, 0, 0, mk(OP_NOTIFY, 48'h0200_0000_0030, 2'd3, 0, 0, 0, 0, 0, 0, 0),
               1, vok};                                   // type 3 never redirects
        rows.push_back(rw);
        rw = '{0, 0, 0, base, 1, vpass};
        rw.r.mac = 48'h0200_0000_0030;
        rows.push_back(rw);
        rw = '{0, 0, 0, mk(OP_NOTIFY, 48'h0200_0000_0031, 2'd2, 0, 0, 0, 0, 0, 0, 0),
               1, vok};
        rows.push_back(rw);
        rw = '{0, 0, 0, base, 0, none};                   // mobile portal
        rw.r.mac = 48'h0200_0000_0031;
        rows.push_back(rw);
        rw = '{0, 0, 0, base, 1, vpass};
        rw.r.mac = 48'h0200_0000_0040;
        rw.r.dport = 16'd81;
        rows.push_back(rw);
        rw.r.dport = WEB_DST_PORT;
        rw.r.plen = 16'd0;
        rows.push_back(rw);
        rw.r.plen = 16'd5;
        rw.r.head = {"GEX", 32'h0};
        rows.push_back(rw);
        rw.r.opcode = 2'd3;                               // unused opcode
        rw.r.head = base.head;
        rows.push_back(rw);
        rw = '{0, 0, 0, mk(OP_FLUSH, 48'h0, 2'd0, 0, 0, 0, 0, 0, 0, 0), 1, vflush};
        rows.push_back(rw);
        rw = '{0, 0, 0, base, 0, none};                   // same MAC after flush
        rw.r.mac = 48'hFFFF_FFFF_FFFF;
        rows.push_back(rw);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].cfg_first) begin
                write_reg(CFG_FORCE, {2'b0, rows[i].fe});
                write_reg(CFG_MASK, rows[i].mask);
            end
            send_request(rows[i].r, rows[i].typed, rows[i].v);
        end

        // random phases: {force, mask} per phase
        phase_cfg = '{4'b0_000, 4'b1_111, 4'b1_001, 4'b1_010, 4'b1_100, 4'b1_000, 4'b1_101};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_FORCE, {2'b0, phase_cfg[ph][3]});
            write_reg(CFG_MASK, phase_cfg[ph][2:0]);
            if (ph >= 3 && ph < 5) begin
                tx_idle_pct = 82;
                rx_idle_pct = 23;
            end else if (ph >= 5) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // overfill the table so full-table notifies and drops occur
            if (ph == 1 || ph == 5) begin
                for (int j = 0; j < ENTRIES + 6; j++)
                    send_request(mk(OP_NOTIFY, mac_pool[j], 2'($urandom_range(3)),
                                    0, 0, 0, 0, 0, 0, 0), 0, none);
            end
            for (int j = 0; j < 70; j++) send_request(random_request(), 0, none);
        end

        i_valid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cpr_pkg.sv
hdl/cpr_cell.sv
hdl/cpr_ctrl.sv
hdl/captive_portal_first_request_redirect.sv
test/tb.sv
